// File: rtl/core/mcbm_pkg.sv
// Package for the bailout mode controller: widths, field types, command and
// mode codes, the millisecond reciprocal and the fund saturation helper.
// No dependencies.
package mcbm_pkg;

    localparam int NS_PER_MS = 1000000;

    localparam int NS_W   = 48;
    localparam int ID_W   = 22;
    localparam int PRIO_W = 9;
    localparam int FUND_W = 50;
    localparam int WIDE_W = FUND_W + 2;
    localparam int DIFF_W = NS_W + 1;
    localparam int CODE_W = 2;
    localparam int FLAG_W = 2;

    localparam int FLAG_DONE = 0;
    localparam int FLAG_IDLE = 1;

    // floor(x / NS_PER_MS) = (x * MS_RECIP) >> MS_SHIFT, exact for x < 2**NS_W
    localparam int MS_SHIFT = NS_W + $clog2(NS_PER_MS);
    localparam int RECIP_W  = NS_W + 1;
    localparam int XL_W     = NS_W / 2;
    localparam int XH_W     = NS_W - XL_W;
    localparam int MH_W     = RECIP_W / 2;
    localparam int ML_W     = RECIP_W - MH_W;
    localparam int PROD_W   = NS_W + RECIP_W;
    localparam int MS_W     = PROD_W - MS_SHIFT;

    typedef logic [MS_SHIFT:0] pow_t;
    localparam pow_t POW_SHIFT  = pow_t'(1) << MS_SHIFT;
    localparam pow_t RECIP_FULL = (POW_SHIFT + pow_t'(NS_PER_MS - 1)) / pow_t'(NS_PER_MS);
    localparam logic [RECIP_W-1:0] MS_RECIP = RECIP_FULL[RECIP_W-1:0];

    typedef logic [ID_W-1:0]          id_t;
    typedef logic [PRIO_W-1:0]        prio_t;
    typedef logic [NS_W-1:0]          ns_t;
    typedef logic [MS_W-1:0]          ms_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [FUND_W-1:0] fund_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam fund_t FUND_MAX    = {1'b0, {(FUND_W-1){1'b1}}};
    localparam fund_t FUND_MIN    = {1'b1, {(FUND_W-1){1'b0}}};
    localparam fund_t FUND_ONE_MS = fund_t'(NS_PER_MS);

    typedef enum logic [1:0] {
        CMD_RELEASE = 2'd0,
        CMD_SCHED   = 2'd1,
        CMD_ADMIT   = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'b001,
        MODE_BAILOUT  = 3'b010,
        MODE_RECOVERY = 3'b100
    } mode_t;

    localparam logic [CODE_W-1:0] CODE_NORMAL   = 2'd0;
    localparam logic [CODE_W-1:0] CODE_BAILOUT  = 2'd1;
    localparam logic [CODE_W-1:0] CODE_RECOVERY = 2'd2;

    typedef struct packed {
        cmd_t              cmd;
        logic              batch_first;
        id_t               job_id;
        prio_t             job_prio;
        logic              job_hc;
        ns_t               job_lo;
        id_t               run_id;
        logic              run_hc;
        ns_t               run_time;
        ns_t               run_lo;
        ns_t               run_hi;
        logic [FLAG_W-1:0] flags;
    } raw_t;

    typedef struct packed {
        cmd_t              cmd;
        logic              batch_first;
        id_t               job_id;
        prio_t             job_prio;
        logic              job_hc;
        ns_t               job_lo;
        id_t               run_id;
        logic              exists;
        logic              run_hc;
        logic [FLAG_W-1:0] flags;
        logic              st_gt_clo;
        logic              ms_gt;
        logic              ms_lt;
        diff_t             over;
        diff_t             hi_rem;
        diff_t             lo_rem;
    } evt_t;

    function automatic fund_t sat_fund(wide_t v);
        wide_t hi;
        wide_t lo;
        hi = wide_t'(FUND_MAX);
        lo = wide_t'(FUND_MIN);
        if (v > hi) begin
            return FUND_MAX;
        end else if (v < lo) begin
            return FUND_MIN;
        end
        return v[FUND_W-1:0];
    endfunction

    function automatic logic [CODE_W-1:0] mode_code(mode_t m);
        logic [CODE_W-1:0] c;
        unique case (m)
            MODE_NORMAL:   c = CODE_NORMAL;
            MODE_BAILOUT:  c = CODE_BAILOUT;
            MODE_RECOVERY: c = CODE_RECOVERY;
            default:       c = CODE_NORMAL;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/mixed_criticality_bailout_mode_core.sv
// Top level of the bailout mode controller: front pipeline and mode state.
// Uses mcbm_pkg, mcbm_prep and mcbm_mode_ctl.
//
//   channel   ports        handshake          payload
//   input     s_*          s_valid/s_ready    command, job and running-task data
//   result    m_*          m_valid/m_ready    mode, fund, watched id, abandoned
//
// One item per cycle while m_ready is high; an item passes the input register,
// the difference register, the comparison register and the result register.
// A reciprocal multiply turns run time and low budget to whole ms before the update.
// Synchronous active-low reset clears mode, fund, watched job and all valids.
// With m_ready low the result holds and the three front stages fill before
// s_ready drops.
module mixed_criticality_bailout_mode_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_command,
    input  logic                          s_batch_first,
    input  logic [mcbm_pkg::ID_W-1:0]     s_job_id,
    input  logic [mcbm_pkg::PRIO_W-1:0]   s_job_prio,
    input  logic                          s_job_high_crit,
    input  logic [mcbm_pkg::NS_W-1:0]     s_job_wcet_lo,
    input  logic [mcbm_pkg::ID_W-1:0]     s_run_id,
    input  logic                          s_run_high_crit,
    input  logic [mcbm_pkg::NS_W-1:0]     s_run_time,
    input  logic [mcbm_pkg::NS_W-1:0]     s_run_wcet_lo,
    input  logic [mcbm_pkg::NS_W-1:0]     s_run_wcet_hi,
    input  logic [mcbm_pkg::FLAG_W-1:0]   s_sched_flags,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mcbm_pkg::CODE_W-1:0]   m_mode_now,
    output logic signed [mcbm_pkg::FUND_W-1:0] m_fund_now,
    output logic [mcbm_pkg::ID_W-1:0]     m_watched_id,
    output logic                          m_abandoned
);

    mcbm_pkg::raw_t  raw;
    mcbm_pkg::evt_t  evt;
    mcbm_pkg::fund_t fund_now;
    logic            evt_valid;
    logic            evt_ready;

    assign raw.cmd         = mcbm_pkg::cmd_t'(s_command);
    assign raw.batch_first = s_batch_first;
    assign raw.job_id      = s_job_id;
    assign raw.job_prio    = s_job_prio;
    assign raw.job_hc      = s_job_high_crit;
    assign raw.job_lo      = s_job_wcet_lo;
    assign raw.run_id      = s_run_id;
    assign raw.run_hc      = s_run_high_crit;
    assign raw.run_time    = s_run_time;
    assign raw.run_lo      = s_run_wcet_lo;
    assign raw.run_hi      = s_run_wcet_hi;
    assign raw.flags       = s_sched_flags;

    mcbm_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .raw       (raw),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt)
    );

    mcbm_mode_ctl u_mode_ctl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .evt_valid    (evt_valid),
        .evt_ready    (evt_ready),
        .evt          (evt),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_mode_now   (m_mode_now),
        .m_fund_now   (fund_now),
        .m_watched_id (m_watched_id),
        .m_abandoned  (m_abandoned)
    );

    assign m_fund_now = fund_now;

endmodule

// File: rtl/core/mcbm_ms_div.sv
// Nanosecond to whole-millisecond conversion by reciprocal multiplication.
// Four registered partial products, then the sum and shift. Uses mcbm_pkg.
module mcbm_ms_div (
    input  logic             aclk,
    input  logic             en,
    input  mcbm_pkg::ns_t    ns,
    output mcbm_pkg::ms_t    ms
);

    localparam int XL_W   = mcbm_pkg::XL_W;
    localparam int XH_W   = mcbm_pkg::XH_W;
    localparam int ML_W   = mcbm_pkg::ML_W;
    localparam int MH_W   = mcbm_pkg::MH_W;
    localparam int PROD_W = mcbm_pkg::PROD_W;
    localparam int LL_W   = XL_W + ML_W;
    localparam int LH_W   = XL_W + MH_W;
    localparam int HL_W   = XH_W + ML_W;
    localparam int HH_W   = XH_W + MH_W;

    localparam logic [ML_W-1:0] RECIP_L = mcbm_pkg::MS_RECIP[ML_W-1:0];
    localparam logic [MH_W-1:0] RECIP_H = mcbm_pkg::MS_RECIP[ML_W +: MH_W];

    logic [LL_W-1:0]   p_ll_reg;
    logic [LH_W-1:0]   p_lh_reg;
    logic [HL_W-1:0]   p_hl_reg;
    logic [HH_W-1:0]   p_hh_reg;
    logic [PROD_W-1:0] prod;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_ll_reg <= LL_W'(ns[XL_W-1:0]) * LL_W'(RECIP_L);
            p_lh_reg <= LH_W'(ns[XL_W-1:0]) * LH_W'(RECIP_H);
            p_hl_reg <= HL_W'(ns[XL_W +: XH_W]) * HL_W'(RECIP_L);
            p_hh_reg <= HH_W'(ns[XL_W +: XH_W]) * HH_W'(RECIP_H);
        end
    end

    assign prod = (PROD_W'(p_hh_reg) << (XL_W + ML_W))
                + (PROD_W'(p_hl_reg) << XL_W)
                + (PROD_W'(p_lh_reg) << ML_W)
                + PROD_W'(p_ll_reg);

    assign ms = prod[mcbm_pkg::MS_SHIFT +: mcbm_pkg::MS_W];

endmodule

// File: rtl/core/mcbm_prep.sv
// Front pipeline: input register, budget differences and millisecond
// conversion, comparison register. Uses mcbm_pkg and mcbm_ms_div.
module mcbm_prep (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mcbm_pkg::raw_t    raw,
    output logic              evt_valid,
    input  logic              evt_ready,
    output mcbm_pkg::evt_t    evt
);

    logic           v0_reg;
    logic           v1_reg;
    logic           v2_reg;
    logic           adv0;
    logic           adv1;
    logic           adv2;
    logic           exists_in;
    mcbm_pkg::raw_t raw_reg;
    mcbm_pkg::raw_t raw_next;
    mcbm_pkg::evt_t e1_reg;
    mcbm_pkg::evt_t e1_next;
    mcbm_pkg::evt_t e2_reg;
    mcbm_pkg::evt_t e2_next;
    mcbm_pkg::ms_t  ms_time;
    mcbm_pkg::ms_t  ms_lo;

    assign adv2    = !v2_reg || evt_ready;
    assign adv1    = !v1_reg || adv2;
    assign adv0    = !v0_reg || adv1;
    assign s_ready = adv0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv0) begin
                v0_reg <= s_valid;
            end
            if (adv1) begin
                v1_reg <= v0_reg;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    // zero the running-task data when no task runs
    assign exists_in = raw.run_id != '0;

    always_comb begin
        raw_next          = raw;
        raw_next.run_hc   = raw.run_hc && exists_in;
        raw_next.run_time = exists_in ? raw.run_time : '0;
        raw_next.run_lo   = exists_in ? raw.run_lo : '0;
        raw_next.run_hi   = exists_in ? raw.run_hi : '0;
    end

    always_comb begin
        e1_next.cmd         = raw_reg.cmd;
        e1_next.batch_first = raw_reg.batch_first;
        e1_next.job_id      = raw_reg.job_id;
        e1_next.job_prio    = raw_reg.job_prio;
        e1_next.job_hc      = raw_reg.job_hc;
        e1_next.job_lo      = raw_reg.job_lo;
        e1_next.run_id      = raw_reg.run_id;
        e1_next.exists      = raw_reg.run_id != '0;
        e1_next.run_hc      = raw_reg.run_hc;
        e1_next.flags       = raw_reg.flags;
        e1_next.st_gt_clo   = raw_reg.run_time > raw_reg.run_lo;
        e1_next.ms_gt       = 1'b0;
        e1_next.ms_lt       = 1'b0;
        e1_next.over   = mcbm_pkg::diff_t'({1'b0, raw_reg.run_hi})
                       - mcbm_pkg::diff_t'({1'b0, raw_reg.run_lo});
        e1_next.hi_rem = mcbm_pkg::diff_t'({1'b0, raw_reg.run_hi})
                       - mcbm_pkg::diff_t'({1'b0, raw_reg.run_time});
        e1_next.lo_rem = mcbm_pkg::diff_t'({1'b0, raw_reg.run_lo})
                       - mcbm_pkg::diff_t'({1'b0, raw_reg.run_time});
    end

    always_comb begin
        e2_next       = e1_reg;
        e2_next.ms_gt = ms_time > ms_lo;
        e2_next.ms_lt = ms_time < ms_lo;
    end

    always_ff @(posedge aclk) begin
        if (adv0 && s_valid) begin
            raw_reg <= raw_next;
        end
        if (adv1) begin
            e1_reg <= e1_next;
        end
        if (adv2) begin
            e2_reg <= e2_next;
        end
    end

    mcbm_ms_div u_div_time (
        .aclk (aclk),
        .en   (adv1),
        .ns   (raw_reg.run_time),
        .ms   (ms_time)
    );

    mcbm_ms_div u_div_lo (
        .aclk (aclk),
        .en   (adv1),
        .ns   (raw_reg.run_lo),
        .ms   (ms_lo)
    );

    assign evt_valid = v2_reg;
    assign evt       = e2_reg;

endmodule

// File: rtl/core/mcbm_mode_ctl.sv
// Mode, fund and watched-job state with the result register.
// Applies one event per load. Uses mcbm_pkg.
module mcbm_mode_ctl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          evt_valid,
    output logic                          evt_ready,
    input  mcbm_pkg::evt_t                evt,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mcbm_pkg::CODE_W-1:0]   m_mode_now,
    output mcbm_pkg::fund_t               m_fund_now,
    output mcbm_pkg::id_t                 m_watched_id,
    output logic                          m_abandoned
);

    mcbm_pkg::mode_t mode_reg;
    mcbm_pkg::mode_t mode_next;
    mcbm_pkg::fund_t fund_reg;
    mcbm_pkg::fund_t fund_next;
    mcbm_pkg::id_t   watch_id_reg;
    mcbm_pkg::id_t   watch_id_next;
    mcbm_pkg::prio_t watch_prio_reg;
    mcbm_pkg::prio_t watch_prio_next;
    logic            abandoned_reg;
    logic            abandoned_next;
    logic            m_valid_reg;
    logic            load;

    assign evt_ready = !m_valid_reg || m_ready;
    assign load      = evt_valid && evt_ready;

    always_comb begin
        mode_next       = mode_reg;
        fund_next       = fund_reg;
        watch_id_next   = watch_id_reg;
        watch_prio_next = watch_prio_reg;
        abandoned_next  = 1'b0;
        unique case (evt.cmd)
            mcbm_pkg::CMD_RELEASE: begin
                if (evt.batch_first && mode_next != mcbm_pkg::MODE_BAILOUT
                        && evt.st_gt_clo) begin
                    mode_next = mcbm_pkg::MODE_BAILOUT;
                    fund_next = mcbm_pkg::fund_t'(evt.over);
                end
                if (mode_next != mcbm_pkg::MODE_RECOVERY
                        && (watch_id_next == '0 || evt.job_prio > watch_prio_next)) begin
                    watch_id_next   = evt.job_id;
                    watch_prio_next = evt.job_prio;
                end
                if (mode_next != mcbm_pkg::MODE_NORMAL && !evt.job_hc) begin
                    abandoned_next = 1'b1;
                    fund_next = mcbm_pkg::sat_fund(mcbm_pkg::wide_t'(fund_next)
                              - mcbm_pkg::wide_t'({1'b0, evt.job_lo}));
                    if (mode_next == mcbm_pkg::MODE_BAILOUT
                            && fund_next < mcbm_pkg::FUND_ONE_MS) begin
                        mode_next = mcbm_pkg::MODE_RECOVERY;
                        fund_next = '0;
                    end
                end
            end
            mcbm_pkg::CMD_SCHED: begin
                if (evt.exists && evt.flags[mcbm_pkg::FLAG_DONE]) begin
                    if (mode_next == mcbm_pkg::MODE_BAILOUT) begin
                        // donate slack of the completing job
                        if (evt.run_hc && evt.ms_gt) begin
                            fund_next = mcbm_pkg::sat_fund(mcbm_pkg::wide_t'(fund_next)
                                      - mcbm_pkg::wide_t'(evt.hi_rem));
                        end else if (!evt.run_hc || evt.ms_lt) begin
                            fund_next = mcbm_pkg::sat_fund(mcbm_pkg::wide_t'(fund_next)
                                      - mcbm_pkg::wide_t'(evt.lo_rem));
                        end
                        if (fund_next[mcbm_pkg::FUND_W-1] || fund_next == '0) begin
                            mode_next = mcbm_pkg::MODE_RECOVERY;
                        end
                    end
                    if (mode_next == mcbm_pkg::MODE_RECOVERY && evt.ms_gt) begin
                        fund_next = mcbm_pkg::fund_t'(evt.over);
                        mode_next = mcbm_pkg::MODE_BAILOUT;
                    end
                    if (mode_next == mcbm_pkg::MODE_RECOVERY
                            && evt.run_id == watch_id_next) begin
                        watch_id_next = '0;
                        mode_next     = mcbm_pkg::MODE_NORMAL;
                        fund_next     = '0;
                    end
                end
                if (evt.ms_gt) begin
                    if (mode_next == mcbm_pkg::MODE_NORMAL) begin
                        fund_next = mcbm_pkg::fund_t'(evt.over);
                        mode_next = mcbm_pkg::MODE_BAILOUT;
                    end else if (mode_next == mcbm_pkg::MODE_BAILOUT) begin
                        fund_next = mcbm_pkg::sat_fund(mcbm_pkg::wide_t'(fund_next)
                                  + mcbm_pkg::wide_t'(evt.over));
                    end
                end
                if (evt.flags[mcbm_pkg::FLAG_IDLE] && mode_next == mcbm_pkg::MODE_BAILOUT) begin
                    mode_next     = mcbm_pkg::MODE_NORMAL;
                    watch_id_next = '0;
                    fund_next     = '0;
                end
            end
            mcbm_pkg::CMD_ADMIT: begin
                watch_id_next = '0;
            end
            mcbm_pkg::CMD_UNUSED: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= mcbm_pkg::MODE_NORMAL;
            fund_reg       <= '0;
            watch_id_reg   <= '0;
            watch_prio_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (evt_ready) begin
                m_valid_reg <= evt_valid;
            end
            if (load) begin
                mode_reg       <= mode_next;
                fund_reg       <= fund_next;
                watch_id_reg   <= watch_id_next;
                watch_prio_reg <= watch_prio_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            abandoned_reg <= abandoned_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_mode_now   = mcbm_pkg::mode_code(mode_reg);
    assign m_fund_now   = fund_reg;
    assign m_watched_id = watch_id_reg;
    assign m_abandoned  = abandoned_reg;

    a_normal_fund: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == mcbm_pkg::MODE_NORMAL |-> fund_reg == '0)
        else $error("fund not zero in normal mode");

    a_recovery_fund: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == mcbm_pkg::MODE_RECOVERY
            |-> (fund_reg[mcbm_pkg::FUND_W-1] || fund_reg == '0))
        else $error("positive fund in recovery mode");

    a_abandon_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && abandoned_reg) |-> mode_reg != mcbm_pkg::MODE_NORMAL)
        else $error("abandoned item reported in normal mode");

    a_hold_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> ($stable(mode_reg) && $stable(fund_reg)
            && $stable(watch_id_reg) && $stable(abandoned_reg)))
        else $error("state changed while result stalled");

endmodule
